// ----- hw/rtl/gdc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdc_pkg
// Shared types, constants and small tables for the Gregorian date converter.
// ----------------------------------------------------------------------------
package gdc_pkg;

  typedef enum logic {
    CMD_TO_SERIAL = 1'b0,
    CMD_TO_DATE   = 1'b1
  } cmd_t;

  localparam int TDATA_W = 48;

  // year estimate: floor((2000 * days + 2956) / 730485), biased by two
  // periods so the dividend never goes negative
  localparam int                 EST_W     = 34;
  localparam int                 EST_SHIFT = 35;
  localparam logic [15:0]        EST_RECIP = 16'd47036;   // floor(2^35 / 730485)
  localparam logic [19:0]        EST_DIV   = 20'd730485;
  localparam logic signed [35:0] EST_MUL   = 36'sd2000;
  localparam logic signed [35:0] EST_BIAS  = 36'sd1463926; // 2956 + 2 * 730485

  // century split of a year offset by 400
  localparam logic [9:0]         C100_RECIP = 10'd655;    // floor(2^16 / 100)
  localparam logic [14:0]        C100       = 15'd100;

  localparam logic [21:0]        SERIAL_MAX = 22'h3FFFFF;
  localparam logic [13:0]        YEAR_MAX   = 14'd9999;

  // one item as it travels down the pipeline
  typedef struct packed {
    logic               cmd;
    logic [4:0]         day;
    logic [3:0]         mon;
    logic [13:0]        yr;
    logic [21:0]        ser;
    logic signed [23:0] days;
  } item_t;

  // day count at the start of a March-based year
  typedef struct packed {
    logic signed [15:0] year;
    logic signed [23:0] yd;
    logic               leap;
  } ydays_t;

  // month counted from March: (mon + 9) mod 12
  function automatic logic [3:0] mar_month(input logic [3:0] mon);
    logic [4:0] t;
    t = {1'b0, mon} + 5'd9;
    if (t >= 5'd24) begin
      mar_month = 4'(t - 5'd24);
    end else if (t >= 5'd12) begin
      mar_month = 4'(t - 5'd12);
    end else begin
      mar_month = t[3:0];
    end
  endfunction

  // days from 1 March to the first of the k-th month after March
  function automatic logic [8:0] month_off(input logic [3:0] k);
    logic [8:0] v;
    case (k)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd92;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd184;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd245;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd337;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // month index of a day within a March-based year
  function automatic logic [3:0] month_idx(input logic [8:0] rem);
    logic [3:0] cnt;
    cnt = '0;
    for (int k = 1; k < 12; k++) begin
      if (rem >= month_off(4'(k))) cnt = cnt + 4'd1;
    end
    return cnt;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/gregorian_date_day_number_convert.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gregorian_date_day_number_convert
// Pipelined converter between Gregorian dates and serial day numbers.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per conversion. in_tuser is the command (0 = date to
//           serial, 1 = serial to date); in_tdata carries day, month, year and
//           serial. Fields that the command does not use are ignored.
//   out_* : one beat per input beat, in order. out_tuser flags a date that
//           exists (command 0) or a serial inside years 0..9999 (command 1).
//   Throughput is one beat per cycle unless out_tready holds the pipeline:
//   a fifteen-stage register pipeline plus the output register, with two
//   year-table units and a reciprocal-multiply year estimate as the stages.
//   Reset (rst_n low, synchronous) clears all stage valid bits; no beat is
//   presented after reset until new input arrives.
//   When out_tready is low while a beat is shown, the whole pipeline holds
//   and in_tready drops in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module gregorian_date_day_number_convert import gdc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // day[4:0], month[8:5], year[22:9], serial[44:23]
  input  logic               in_tuser,   // command
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // day[4:0], month[8:5], year[22:9], serial[44:23]
  output logic               out_tuser   // valid_res
);

  logic        en;
  logic [15:0] vld_r;

  assign en        = !vld_r[15] || out_tready;
  assign in_tready = en;
  assign out_tvalid = vld_r[15];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[14:0], in_tvalid};
    end
  end

  // decode: March-based month and year, partial day count
  logic [3:0]         mm_in;
  logic signed [15:0] y0_nxt;
  logic signed [15:0] y0_r;
  item_t              dec;

  assign mm_in  = mar_month(in_tdata[8:5]);
  assign y0_nxt = signed'(16'(in_tdata[22:9])) - ((mm_in >= 4'd10) ? 16'sd1 : 16'sd0);

  always_comb begin
    dec.cmd = in_tuser;
    dec.day = in_tdata[4:0];
    dec.mon = in_tdata[8:5];
    dec.yr  = in_tdata[22:9];
    dec.ser = in_tdata[44:23];
    if (in_tuser == CMD_TO_DATE) begin
      dec.days = signed'(24'(in_tdata[44:23])) - 24'sd1;
    end else begin
      dec.days = signed'(24'(month_off(mm_in))) + signed'(24'(in_tdata[4:0])) - 24'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) y0_r <= y0_nxt;
  end

  // forward year table, result lines up with stage 3
  ydays_t ya;

  gdc_year_days u_fwd_days (
    .clk    (clk),
    .en     (en),
    .year_i (y0_r),
    .res_o  (ya)
  );

  // item line, day count finished at stage 4
  item_t item_r   [0:14];
  item_t item_nxt [0:14];

  always_comb begin
    item_nxt[0] = dec;
    for (int k = 1; k < 15; k++) item_nxt[k] = item_r[k-1];
    if (item_r[3].cmd != CMD_TO_DATE) begin
      item_nxt[4].days = ya.yd + item_r[3].days;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 15; k++) item_r[k] <= item_nxt[k];
    end
  end

  // year estimate from stage 4, ready at stage 8
  logic signed [15:0] yy_est;

  gdc_year_est u_est (
    .clk    (clk),
    .en     (en),
    .days_i (item_r[4].days),
    .year_o (yy_est)
  );

  // table for the estimate, ready at stage 11
  ydays_t yb;

  gdc_year_days u_inv_days (
    .clk    (clk),
    .en     (en),
    .year_i (yy_est),
    .res_o  (yb)
  );

  // stage 12: day within year, step back one year when negative
  logic signed [23:0] rem_hi;
  logic signed [23:0] rem_lo;
  logic [8:0]         rem12_r;
  logic signed [15:0] yf12_r;

  assign rem_hi = item_r[11].days - yb.yd;
  assign rem_lo = rem_hi + 24'sd365 + (yb.leap ? 24'sd1 : 24'sd0);

  always_ff @(posedge clk) begin
    if (en) begin
      rem12_r <= rem_hi[23] ? rem_lo[8:0] : rem_hi[8:0];
      yf12_r  <= rem_hi[23] ? yb.year - 16'sd1 : yb.year;
    end
  end

  // stage 13: month index
  logic [3:0]         mi13_r;
  logic [8:0]         rem13_r;
  logic signed [15:0] yf13_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mi13_r  <= month_idx(rem12_r);
      rem13_r <= rem12_r;
      yf13_r  <= yf12_r;
    end
  end

  // stage 14: calendar day, month and year
  logic [8:0]         d_full;
  logic               wrap;
  logic [4:0]         d14_r;
  logic [3:0]         m14_r;
  logic signed [15:0] y14_r;

  assign d_full = rem13_r - month_off(mi13_r) + 9'd1;
  assign wrap   = (mi13_r >= 4'd10);

  always_ff @(posedge clk) begin
    if (en) begin
      d14_r <= d_full[4:0];
      m14_r <= wrap ? mi13_r - 4'd9 : mi13_r + 4'd3;
      y14_r <= yf13_r + (wrap ? 16'sd1 : 16'sd0);
    end
  end

  // stage 15: output register
  item_t              it;
  logic signed [23:0] s15;
  logic               fits;
  logic               match;
  logic               in_range;
  logic [4:0]         dout_nxt;
  logic [3:0]         mout_nxt;
  logic [13:0]        yout_nxt;
  logic [21:0]        sout_nxt;
  logic               vres_nxt;
  logic [4:0]         dout_r;
  logic [3:0]         mout_r;
  logic [13:0]        yout_r;
  logic [21:0]        sout_r;
  logic               vres_r;

  assign it       = item_r[14];
  assign s15      = it.days + 24'sd1;
  assign fits     = !s15[23] && (s15 <= signed'(24'(SERIAL_MAX)));
  assign match    = (d14_r == it.day) && (m14_r == it.mon)
                  && (y14_r == signed'(16'(it.yr)));
  assign in_range = !y14_r[15] && (y14_r <= signed'(16'(YEAR_MAX)));

  always_comb begin
    if (it.cmd == CMD_TO_DATE) begin
      dout_nxt = in_range ? d14_r : 5'd0;
      mout_nxt = in_range ? m14_r : 4'd0;
      yout_nxt = in_range ? y14_r[13:0] : 14'd0;
      sout_nxt = it.ser;
      vres_nxt = in_range;
    end else begin
      dout_nxt = it.day;
      mout_nxt = it.mon;
      yout_nxt = it.yr;
      sout_nxt = fits ? s15[21:0] : 22'd0;
      vres_nxt = fits && (s15 != 24'sd0) && match;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout_r <= dout_nxt;
      mout_r <= mout_nxt;
      yout_r <= yout_nxt;
      sout_r <= sout_nxt;
      vres_r <= vres_nxt;
    end
  end

  assign out_tdata = {3'b000, sout_r, yout_r, mout_r, dout_r};
  assign out_tuser = vres_r;

endmodule
`default_nettype wire

// ----- hw/rtl/gdc_year_days.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdc_year_days
// Three-stage unit: days before a March-based year and its leap flag.
// ----------------------------------------------------------------------------
module gdc_year_days import gdc_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] year_i,
  output ydays_t             res_o
);

  // stage A: offset the year by 400 and estimate the century count
  logic signed [15:0] ya_r;
  logic [14:0]        xa_r;
  logic [7:0]         qa_r;
  logic [14:0]        x_nxt;
  logic [24:0]        prod_a;

  assign x_nxt  = 15'(year_i + 16'sd400);
  assign prod_a = 25'(x_nxt) * 25'(C100_RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      ya_r <= year_i;
      xa_r <= x_nxt;
      qa_r <= prod_a[23:16];
    end
  end

  // stage B: correct the estimate by one, keep whether the remainder is zero
  logic signed [15:0] yb_r;
  logic [7:0]         q100_r;
  logic               z100_r;
  logic [14:0]        ra;
  logic               up;
  logic [14:0]        r100;

  assign ra   = xa_r - 15'({7'd0, qa_r} * C100);
  assign up   = (ra >= C100);
  assign r100 = up ? ra - C100 : ra;

  always_ff @(posedge clk) begin
    if (en) begin
      yb_r   <= ya_r;
      q100_r <= up ? qa_r + 8'd1 : qa_r;
      z100_r <= (r100 == 15'd0);
    end
  end

  // stage C: 365*y + y/4 - y/100 + y/400 with floor division
  logic signed [23:0] ys;
  logic signed [23:0] qs;
  logic signed [23:0] yd_nxt;
  ydays_t             res_r;

  assign ys     = 24'(yb_r);
  assign qs     = signed'({16'd0, q100_r});
  assign yd_nxt = ys * 24'sd365 + (ys >>> 2) - qs + (qs >>> 2) + 24'sd3;

  always_ff @(posedge clk) begin
    if (en) begin
      res_r.year <= yb_r;
      res_r.yd   <= yd_nxt;
      res_r.leap <= (yb_r[1:0] == 2'b00) && (!z100_r || (q100_r[1:0] == 2'b00));
    end
  end

  assign res_o = res_r;

endmodule
`default_nettype wire

// ----- hw/rtl/gdc_year_est.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdc_year_est
// Four-stage year estimate from a day count: reciprocal multiply, one fixup.
// ----------------------------------------------------------------------------
module gdc_year_est import gdc_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [23:0] days_i,
  output logic signed [15:0] year_o
);

  // stage 1: biased dividend, always positive
  logic signed [35:0] n_full;
  logic [EST_W-1:0]   n1_r;

  assign n_full = 36'(days_i) * EST_MUL + EST_BIAS;

  always_ff @(posedge clk) begin
    if (en) n1_r <= n_full[EST_W-1:0];
  end

  // stage 2: quotient estimate, low by at most one
  logic [49:0]      prod;
  logic [14:0]      q2_r;
  logic [EST_W-1:0] n2_r;

  assign prod = 50'(n1_r) * 50'(EST_RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      q2_r <= prod[EST_SHIFT +: 15];
      n2_r <= n1_r;
    end
  end

  // stage 3: back-multiply
  logic [34:0]      back;
  logic [EST_W-1:0] p3_r;
  logic [EST_W-1:0] n3_r;
  logic [14:0]      q3_r;

  assign back = 35'(q2_r) * 35'(EST_DIV);

  always_ff @(posedge clk) begin
    if (en) begin
      p3_r <= back[EST_W-1:0];
      n3_r <= n2_r;
      q3_r <= q2_r;
    end
  end

  // stage 4: fix up and remove the bias
  logic [EST_W-1:0]   r4;
  logic signed [15:0] year_nxt;
  logic signed [15:0] year_r;

  assign r4       = n3_r - p3_r;
  assign year_nxt = signed'({1'b0, q3_r}) - 16'sd2
                  + ((r4 >= EST_W'(EST_DIV)) ? 16'sd1 : 16'sd0);

  always_ff @(posedge clk) begin
    if (en) year_r <= year_nxt;
  end

  assign year_o = year_r;

endmodule
`default_nettype wire
